// File: design/mlbc_pkg.sv
// Package for the LED blink controller: sizes, command codes and shared types.
`default_nettype none
package mlbc_pkg;

  localparam int LED_COUNT   = 16;
  localparam int IDX_W       = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int OUT_W       = 16;
  localparam int PERIOD_W    = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_LEVEL = 2'd1;
  localparam logic [1:0] ACT_BLINK = 2'd2;

  localparam logic [1:0] LVL_OFF    = 2'd0;
  localparam logic [1:0] LVL_ON     = 2'd1;
  localparam logic [1:0] LVL_TOGGLE = 2'd2;

  typedef enum logic [2:0] {
    K_NOP    = 3'd0,
    K_TICK   = 3'd1,
    K_OFF    = 3'd2,
    K_ON     = 3'd3,
    K_TOGGLE = 3'd4,
    K_BLINK  = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [IDX_W-1:0]     idx;
    logic                 enable;
    logic [PERIOD_W-1:0]  period;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } slot_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_t;

  // Bits at or above the LED count read as dark.
  function automatic logic [OUT_W-1:0] expand_levels(input logic [LED_COUNT-1:0] lv);
    logic [OUT_W-1:0] r;
    r = '1;
    for (int i = 0; i < OUT_W; i++) begin
      if (i < LED_COUNT) begin
        r[i] = lv[i];
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/mlbc_req_if.sv
// Request channel of the LED blink controller.
`default_nettype none
interface mlbc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [4:0]  led_index;
  logic [1:0]  level_command;
  logic        blink_enable;
  logic [15:0] blink_period;

  modport source (output valid, action, led_index, level_command, blink_enable,
                  blink_period, input ready);
  modport sink (input valid, action, led_index, level_command, blink_enable,
                blink_period, output ready);
endinterface
`default_nettype wire

// File: design/mlbc_rsp_if.sv
// Response channel of the LED blink controller.
`default_nettype none
interface mlbc_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] led_levels;

  modport source (output valid, led_levels, input ready);
  modport sink (input valid, led_levels, output ready);
endinterface
`default_nettype wire

// File: design/mlbc_front.sv
// Front end: accepts requests and classifies them into queue entries.
`default_nettype none
module mlbc_front (
  mlbc_req_if.sink         req,
  input  logic             full,
  output mlbc_pkg::slot_t  push
);

  logic idx_ok;
  mlbc_pkg::kind_t kind;

  assign idx_ok = ({1'b0, req.led_index} < 6'(mlbc_pkg::LED_COUNT));

  always_comb begin
    kind = mlbc_pkg::K_NOP;
    case (req.action)
      mlbc_pkg::ACT_TICK: begin
        kind = mlbc_pkg::K_TICK;
      end
      mlbc_pkg::ACT_LEVEL: begin
        if (idx_ok) begin
          case (req.level_command)
            mlbc_pkg::LVL_OFF:    kind = mlbc_pkg::K_OFF;
            mlbc_pkg::LVL_ON:     kind = mlbc_pkg::K_ON;
            mlbc_pkg::LVL_TOGGLE: kind = mlbc_pkg::K_TOGGLE;
            default:              kind = mlbc_pkg::K_NOP;
          endcase
        end
      end
      mlbc_pkg::ACT_BLINK: begin
        if (idx_ok) begin
          kind = mlbc_pkg::K_BLINK;
        end
      end
      default: begin
        kind = mlbc_pkg::K_NOP;
      end
    endcase
  end

  assign req.ready          = !full;
  assign push.valid         = req.valid && !full;
  assign push.entry.kind    = kind;
  assign push.entry.idx     = req.led_index[mlbc_pkg::IDX_W-1:0];
  assign push.entry.enable  = req.blink_enable;
  assign push.entry.period  = req.blink_period;

endmodule
`default_nettype wire

// File: design/mlbc_queue.sv
// Short queue of classified requests between the front and back ends.
`default_nettype none
module mlbc_queue (
  input  logic             clk,
  input  logic             rst,
  input  mlbc_pkg::slot_t  push,
  output logic             full,
  input  logic             pop,
  output mlbc_pkg::slot_t  head
);

  localparam int DEPTH = mlbc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mlbc_pkg::entry_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head.valid = (count != '0);
  assign head.entry = entries[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("queue count exceeds depth");

endmodule
`default_nettype wire

// File: design/mlbc_back.sv
// Back end: applies commands, walks the blink timers on a tick, holds the result.
`default_nettype none
module mlbc_back (
  input  logic             clk,
  input  logic             rst,
  input  mlbc_pkg::slot_t  head,
  output logic             pop,
  mlbc_rsp_if.source       rsp
);

  localparam int N     = mlbc_pkg::LED_COUNT;
  localparam int IDX_W = mlbc_pkg::IDX_W;
  localparam int PW    = mlbc_pkg::PERIOD_W;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(N - 1);

  mlbc_pkg::state_t state;
  mlbc_pkg::state_t state_next;
  logic [IDX_W-1:0]   walk_idx;
  logic [N-1:0]       levels;
  logic [N-1:0]       levels_next;
  logic [N-1:0]       enabled;
  logic [PW-1:0]      period_store [N];
  logic [PW-1:0]      count_store [N];
  logic               out_valid;
  logic [mlbc_pkg::OUT_W-1:0] out_levels;

  logic          out_free;
  logic          step_go;
  logic          step_last;
  logic [PW-1:0] cnt_inc;
  logic          hit;
  logic          load_out;

  assign out_free  = !out_valid || rsp.ready;
  assign pop       = (state == mlbc_pkg::S_IDLE) && head.valid &&
                     ((head.entry.kind == mlbc_pkg::K_TICK) || out_free);
  assign step_last = (walk_idx == LAST);
  assign step_go   = (state == mlbc_pkg::S_WALK) && (!step_last || out_free);
  assign cnt_inc   = count_store[walk_idx] + 1'b1;
  assign hit       = (cnt_inc >= period_store[walk_idx]);
  assign load_out  = (pop && (head.entry.kind != mlbc_pkg::K_TICK)) ||
                     (step_go && step_last);

  always_comb begin
    levels_next = levels;
    state_next  = state;
    case (state)
      mlbc_pkg::S_IDLE: begin
        if (pop) begin
          case (head.entry.kind)
            mlbc_pkg::K_OFF:    levels_next[head.entry.idx] = 1'b1;
            mlbc_pkg::K_ON:     levels_next[head.entry.idx] = 1'b0;
            mlbc_pkg::K_TOGGLE: levels_next[head.entry.idx] = !levels[head.entry.idx];
            mlbc_pkg::K_TICK:   state_next = mlbc_pkg::S_WALK;
            default:            levels_next = levels;
          endcase
        end
      end
      mlbc_pkg::S_WALK: begin
        if (step_go) begin
          if (enabled[walk_idx] && hit) begin
            levels_next[walk_idx] = !levels[walk_idx];
          end
          if (step_last) begin
            state_next = mlbc_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = mlbc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mlbc_pkg::S_IDLE;
      walk_idx <= '0;
      levels   <= '1;
      enabled  <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < N; i++) begin
        period_store[i] <= '0;
        count_store[i]  <= '0;
      end
    end else begin
      state  <= state_next;
      levels <= levels_next;
      if (pop && (head.entry.kind == mlbc_pkg::K_BLINK)) begin
        enabled[head.entry.idx]      <= head.entry.enable;
        period_store[head.entry.idx] <= head.entry.period;
      end
      if (step_go) begin
        walk_idx <= step_last ? '0 : walk_idx + 1'b1;
        if (enabled[walk_idx]) begin
          count_store[walk_idx] <= hit ? '0 : cnt_inc;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_levels <= mlbc_pkg::expand_levels(levels_next);
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.led_levels = out_levels;

  a_idle_idx: assert property (@(posedge clk) disable iff (rst)
    (state == mlbc_pkg::S_IDLE) |-> (walk_idx == '0))
    else $error("walk index not parked while idle");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == mlbc_pkg::S_IDLE))
    else $error("request taken during a timer walk");

  a_levels_hold: assert property (@(posedge clk) disable iff (rst)
    (!rst && (state == mlbc_pkg::S_IDLE) && !pop) |=> $stable(levels))
    else $error("LED levels changed with no request in progress");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (load_out && out_valid) |-> rsp.ready)
    else $error("result register overwritten before it was taken");

endmodule
`default_nettype wire

// File: design/multi_led_blink_controller.sv
// Top level of the LED blink controller: front end, request queue and back end.
// A level or blink-set request passes the queue and then the result register.
// A tick makes the back end walk the blink timers one LED per cycle, its last
// step waiting until the result register is free. Level and blink-set requests
// sustain one per cycle while results are taken; a tick holds the back end
// until its walk ends. Reset darkens every LED and clears all blink state.
`default_nettype none
module multi_led_blink_controller (
  input  logic        clk,
  input  logic        rst,
  mlbc_req_if.sink    req,
  mlbc_rsp_if.source  rsp
);

  mlbc_pkg::slot_t push;
  mlbc_pkg::slot_t head;
  logic            full;
  logic            pop;

  mlbc_front u_front (
    .req  (req),
    .full (full),
    .push (push)
  );

  mlbc_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .pop  (pop),
    .head (head)
  );

  mlbc_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .rsp  (rsp)
  );

endmodule
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the LED blink controller, with a directed table and random requests.
`timescale 1ns / 1ps
module tb;

  localparam int N  = mlbc_pkg::LED_COUNT;
  localparam int PW = mlbc_pkg::PERIOD_W;
  localparam int OW = mlbc_pkg::OUT_W;
  localparam int IW = mlbc_pkg::IDX_W;
  localparam logic [1:0] ACT_TICK   = mlbc_pkg::ACT_TICK;
  localparam logic [1:0] ACT_LEVEL  = mlbc_pkg::ACT_LEVEL;
  localparam logic [1:0] ACT_BLINK  = mlbc_pkg::ACT_BLINK;
  localparam logic [1:0] LVL_OFF    = mlbc_pkg::LVL_OFF;
  localparam logic [1:0] LVL_ON     = mlbc_pkg::LVL_ON;
  localparam logic [1:0] LVL_TOGGLE = mlbc_pkg::LVL_TOGGLE;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [1:0] LVL_UNUSED = 2'd3;
  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_ITEMS = 1125;
  localparam int QUIET_ITEMS = 150;
  localparam int HOLD_AT_ITEM = 400;
  localparam int HOLD_CYCLES = 200;
  localparam int END_CYCLES = N + 8;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [1:0]    action;
    logic [4:0]    idx;
    logic [1:0]    cmd;
    logic          en;
    logic [PW-1:0] period;
    logic          fixed;
    logic [OW-1:0] levels;
  } led_req_t;

  logic clk;
  logic rst;

  mlbc_req_if req_ch ();
  mlbc_rsp_if rsp_ch ();

  multi_led_blink_controller dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  logic [N-1:0]  dark_bits;
  logic          blink_on [N];
  logic [PW-1:0] blink_len [N];
  logic [PW-1:0] blink_ticks [N];

  logic [OW-1:0] levels_pending [$];
  int            error_count;
  int            cycle_count;
  logic          offered_fixed;
  logic [OW-1:0] offered_levels;
  bit            gaps_on;
  bit            hold_off_req;
  bit            hold_off_done;

  led_req_t directed_rows [DIRECTED_ROWS];

  function automatic logic [OW-1:0] next_levels(input led_req_t r);
    logic [PW-1:0] nxt;
    logic [OW-1:0] out;
    logic [IW-1:0] pos;
    pos = r.idx[IW-1:0];
    if (r.action == ACT_TICK) begin
      for (int i = 0; i < N; i++) begin
        if (blink_on[i]) begin
          nxt = blink_ticks[i] + 1'b1;
          if (nxt >= blink_len[i]) begin
            dark_bits[i] = ~dark_bits[i];
            nxt = '0;
          end
          blink_ticks[i] = nxt;
        end
      end
    end else if (r.action == ACT_LEVEL && int'(r.idx) < N) begin
      case (r.cmd)
        LVL_OFF: dark_bits[pos] = 1'b1;
        LVL_ON: dark_bits[pos] = 1'b0;
        LVL_TOGGLE: dark_bits[pos] = ~dark_bits[pos];
        default: ;
      endcase
    end else if (r.action == ACT_BLINK && int'(r.idx) < N) begin
      blink_on[pos] = r.en;
      blink_len[pos] = r.period;
    end
    out = '1;
    for (int i = 0; i < OW; i++) begin
      if (i < N) begin
        out[i] = dark_bits[i];
      end
    end
    return out;
  endfunction

  function automatic led_req_t random_request();
    led_req_t r;
    int       pick;
    r = '0;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      r.action = ACT_TICK;
    end else if (pick < 70) begin
      r.action = ACT_LEVEL;
    end else if (pick < 95) begin
      r.action = ACT_BLINK;
    end else begin
      r.action = ACT_UNUSED;
    end
    if ($urandom_range(0, 9) == 0) begin
      r.idx = 5'($urandom_range(N, 31));
    end else begin
      r.idx = 5'($urandom_range(0, N - 1));
    end
    r.cmd = ($urandom_range(0, 19) == 0) ? LVL_UNUSED : 2'($urandom_range(0, 2));
    r.en = ($urandom_range(0, 4) != 0);
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      r.period = PW'($urandom_range(0, 4));
    end else if (pick < 85) begin
      r.period = PW'($urandom_range(5, 20));
    end else if (pick < 97) begin
      r.period = PW'($urandom);
    end else begin
      r.period = '1;
    end
    return r;
  endfunction

  task automatic offer_request(input led_req_t r);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.action <= r.action;
    req_ch.led_index <= r.idx;
    req_ch.level_command <= r.cmd;
    req_ch.blink_enable <= r.en;
    req_ch.blink_period <= r.period;
    offered_fixed <= r.fixed;
    offered_levels <= r.levels;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (levels_pending.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, rsp_ch.led_levels);
          error_count++;
        end else if (rsp_ch.led_levels !== levels_pending[0]) begin
          $display("%0t: led_levels mismatch, expected %h, got %h", $time, levels_pending[0],
                   rsp_ch.led_levels);
          error_count++;
          void'(levels_pending.pop_front());
        end else begin
          void'(levels_pending.pop_front());
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        led_req_t seen;
        logic [OW-1:0] predicted;
        seen = '0;
        seen.action = req_ch.action;
        seen.idx = req_ch.led_index;
        seen.cmd = req_ch.level_command;
        seen.en = req_ch.blink_enable;
        seen.period = req_ch.blink_period;
        predicted = next_levels(seen);
        levels_pending.push_back(offered_fixed ? offered_levels : predicted);
      end
    end
  end

  initial begin
    int stall_left;
    stall_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) begin
          rsp_ch.ready <= 1'b1;
        end
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 3);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    led_req_t r;
    int       done_items;
    directed_rows = '{
      '{ACT_TICK,   5'd0,  LVL_OFF,    1'b0, 16'h0000, 1'b1, 16'hFFFF},
      '{ACT_LEVEL,  5'd0,  LVL_ON,     1'b0, 16'h0000, 1'b1, 16'hFFFE},
      '{ACT_LEVEL,  5'd15, LVL_ON,     1'b1, 16'hFFFF, 1'b1, 16'h7FFE},
      '{ACT_LEVEL,  5'd15, LVL_TOGGLE, 1'b0, 16'h0000, 1'b1, 16'hFFFE},
      '{ACT_LEVEL,  5'd16, LVL_ON,     1'b0, 16'h0000, 1'b1, 16'hFFFE},
      '{ACT_LEVEL,  5'd31, LVL_ON,     1'b1, 16'hFFFF, 1'b1, 16'hFFFE},
      '{ACT_UNUSED, 5'd0,  LVL_TOGGLE, 1'b1, 16'hFFFF, 1'b1, 16'hFFFE},
      '{ACT_LEVEL,  5'd0,  LVL_UNUSED, 1'b0, 16'h0000, 1'b1, 16'hFFFE},
      '{ACT_LEVEL,  5'd0,  LVL_OFF,    1'b0, 16'h0000, 1'b1, 16'hFFFF},
      '{ACT_BLINK,  5'd31, LVL_OFF,    1'b1, 16'hFFFF, 1'b1, 16'hFFFF},
      '{ACT_BLINK,  5'd0,  LVL_OFF,    1'b1, 16'h0000, 1'b1, 16'hFFFF},
      '{ACT_TICK,   5'd0,  LVL_OFF,    1'b0, 16'h0000, 1'b1, 16'hFFFE},
      '{ACT_TICK,   5'd0,  LVL_OFF,    1'b0, 16'h0000, 1'b1, 16'hFFFF},
      '{ACT_BLINK,  5'd1,  LVL_OFF,    1'b1, 16'h0001, 1'b0, 16'h0000},
      '{ACT_TICK,   5'd0,  LVL_OFF,    1'b0, 16'h0000, 1'b0, 16'h0000},
      '{ACT_BLINK,  5'd15, LVL_OFF,    1'b1, 16'hFFFF, 1'b0, 16'h0000},
      '{ACT_BLINK,  5'd2,  LVL_OFF,    1'b1, 16'h0005, 1'b0, 16'h0000},
      '{ACT_TICK,   5'd0,  LVL_OFF,    1'b0, 16'h0000, 1'b0, 16'h0000},
      '{ACT_TICK,   5'd0,  LVL_OFF,    1'b0, 16'h0000, 1'b0, 16'h0000},
      '{ACT_TICK,   5'd0,  LVL_OFF,    1'b0, 16'h0000, 1'b0, 16'h0000},
      '{ACT_BLINK,  5'd2,  LVL_OFF,    1'b0, 16'h0005, 1'b0, 16'h0000},
      '{ACT_TICK,   5'd0,  LVL_OFF,    1'b0, 16'h0000, 1'b0, 16'h0000},
      '{ACT_BLINK,  5'd2,  LVL_OFF,    1'b1, 16'h0001, 1'b0, 16'h0000},
      '{ACT_TICK,   5'd0,  LVL_OFF,    1'b0, 16'h0000, 1'b0, 16'h0000},
      '{ACT_LEVEL,  5'd2,  LVL_TOGGLE, 1'b0, 16'h0000, 1'b0, 16'h0000}
    };
    dark_bits = '1;
    for (int i = 0; i < N; i++) begin
      blink_on[i] = 1'b0;
      blink_len[i] = '0;
      blink_ticks[i] = '0;
    end
    error_count = 0;
    cycle_count = 0;
    gaps_on = 1'b1;
    hold_off_req = 1'b0;
    hold_off_done = 1'b0;
    offered_fixed <= 1'b0;
    offered_levels <= '0;
    req_ch.valid <= 1'b0;
    req_ch.action <= ACT_TICK;
    req_ch.led_index <= '0;
    req_ch.level_command <= LVL_OFF;
    req_ch.blink_enable <= 1'b0;
    req_ch.blink_period <= '0;
    rst <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      offer_request(directed_rows[i]);
    end

    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      r = random_request();
      offer_request(r);
      done_items++;
      if (done_items == HOLD_AT_ITEM) begin
        hold_off_req = 1'b1;
      end
      if (done_items >= RANDOM_ITEMS - QUIET_ITEMS) begin
        gaps_on = 1'b0;
      end
    end
    req_ch.valid <= 1'b0;

    while (levels_pending.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (error_count == 0 && levels_pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: multi_led_blink_controller.f
design/mlbc_pkg.sv
design/mlbc_req_if.sv
design/mlbc_rsp_if.sv
design/mlbc_front.sv
design/mlbc_queue.sv
design/mlbc_back.sv
design/multi_led_blink_controller.sv
tb/tb.sv
